>>> hw/rtl/dtf_pkg.sv
// Shared types and constants for the decimal-to-fraction converter.
// No dependencies; used by every module of the block but dtf_divider.
`default_nettype none

package dtf_pkg;

   localparam int unsigned PRECISION_DEF = 1000000000;
   localparam int unsigned VALUE_W       = 64;
   localparam int unsigned INT_W         = 32;
   localparam int unsigned FRAC_W        = 32;

   // Operand pair fed to the shared divider
   typedef enum logic [1:0] {
      DIV_GCD = 2'd0,   // gx % gy, one Euclid step
      DIV_NUM = 2'd1,   // scaled / g
      DIV_DEN = 2'd2    // precision / g
   } dtf_div_sel_type;

   typedef struct packed {
      logic            load_in;
      logic            mul_scale;
      logic            load_gcd;
      logic            div_start;
      dtf_div_sel_type div_sel;
      logic            gcd_step;
      logic            take_num;
      logic            take_den;
      logic            mul_den;
      logic            load_out;
   } dtf_cmd_type;

   typedef struct packed {
      logic gy_zero;
      logic div_done;
   } dtf_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/decimal_to_fraction_core.sv
// Decimal-to-fraction converter: a signed Q32.32 value in, numerator, denominator
// and whole flag out. Each transfer is worked one at a time: accept, scaling and
// rounding, then the Euclid remainder steps, then the two divisions by the gcd
// (numerator and denominator), then result assembly; the Euclid steps and both
// divisions run on one shared restoring divider of DEN_W bits (DEN_W = 30 for the
// default precision of 10^9). The result sits in an output register, so the next
// item is taken while it waits to be read; an item that finishes while the
// previous result is still unread stalls until that result is taken.
// Depends on dtf_pkg, dtf_ctrl, dtf_datapath and dtf_divider.
`default_nettype none

module decimal_to_fraction_core #(
   parameter int unsigned PRECISION = dtf_pkg::PRECISION_DEF,
   parameter int unsigned DEN_W     = $clog2(PRECISION + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [dtf_pkg::VALUE_W-1:0] req_value_fixed,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [dtf_pkg::VALUE_W-1:0]      rsp_numerator,
   output logic [DEN_W-1:0]                 rsp_denominator,
   output logic                             rsp_is_whole
);

   dtf_pkg::dtf_cmd_type    cmd;
   dtf_pkg::dtf_status_type status;

   dtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   dtf_datapath #(
      .PRECISION (PRECISION),
      .DEN_W     (DEN_W)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .value_fixed (req_value_fixed),
      .numerator   (rsp_numerator),
      .denominator (rsp_denominator),
      .is_whole    (rsp_is_whole)
   );

endmodule

`default_nettype wire

>>> hw/rtl/dtf_divider.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on nothing beyond its parameter.
`default_nettype none

module dtf_divider #(
   parameter int unsigned W = 30
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quotient,
   output logic [W-1:0]      remainder
);

   localparam int unsigned CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;
   logic          fits;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so W bits hold it
         rem_in = fits ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

`default_nettype wire

>>> hw/rtl/dtf_datapath.sv
// Datapath: input split, fraction scaling, Euclid registers, result assembly.
// Uses dtf_pkg and instantiates dtf_divider.
`default_nettype none

module dtf_datapath #(
   parameter int unsigned PRECISION = dtf_pkg::PRECISION_DEF,
   parameter int unsigned DEN_W     = $clog2(PRECISION + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dtf_pkg::dtf_cmd_type       cmd,
   output dtf_pkg::dtf_status_type         status,
   input  wire logic [dtf_pkg::VALUE_W-1:0] value_fixed,
   output logic [dtf_pkg::VALUE_W-1:0]     numerator,
   output logic [DEN_W-1:0]                denominator,
   output logic                            is_whole
);

   localparam int unsigned INT_W  = dtf_pkg::INT_W;
   localparam int unsigned FRAC_W = dtf_pkg::FRAC_W;
   localparam int unsigned VAL_W  = dtf_pkg::VALUE_W;
   localparam int unsigned SP_W   = FRAC_W + DEN_W;   // fraction times precision
   localparam int unsigned MP_W   = INT_W + DEN_W + 1; // integer part times denominator
   localparam logic [DEN_W-1:0]  PREC_C = DEN_W'(PRECISION);
   localparam logic [SP_W:0]     HALF_C = (SP_W + 1)'(64'h8000_0000);

   logic signed [INT_W-1:0] int_ff, int_in;
   logic [FRAC_W-1:0]       frac_ff, frac_in;
   logic [SP_W-1:0]         sprod_ff, sprod_in;
   logic [SP_W:0]           sround;
   logic [DEN_W-1:0]        scaled_ff, scaled_in;
   logic [DEN_W-1:0]        gx_ff, gx_in;
   logic [DEN_W-1:0]        gy_ff, gy_in;
   logic [DEN_W-1:0]        num_ff, num_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic signed [MP_W-1:0]  mprod_ff, mprod_in;
   logic [VAL_W-1:0]        onum_ff, onum_in;
   logic [DEN_W-1:0]        oden_ff, oden_in;
   logic                    owhole_ff, owhole_in;

   logic [DEN_W-1:0] div_dividend;
   logic [DEN_W-1:0] div_divisor;
   logic             div_done;
   logic [DEN_W-1:0] div_quo;
   logic [DEN_W-1:0] div_rem;

   assign sround = {1'b0, sprod_ff} + HALF_C;

   always_comb begin
      case (cmd.div_sel)
         dtf_pkg::DIV_NUM: begin
            div_dividend = scaled_ff;
            div_divisor  = gx_ff;
         end
         dtf_pkg::DIV_DEN: begin
            div_dividend = PREC_C;
            div_divisor  = gx_ff;
         end
         default: begin
            div_dividend = gx_ff;
            div_divisor  = gy_ff;
         end
      endcase
   end

   dtf_divider #(.W(DEN_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      int_in    = int_ff;
      frac_in   = frac_ff;
      sprod_in  = sprod_ff;
      scaled_in = scaled_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      mprod_in  = mprod_ff;
      onum_in   = onum_ff;
      oden_in   = oden_ff;
      owhole_in = owhole_ff;
      if (cmd.load_in) begin
         // upper half is the floor integer part, lower half a non-negative fraction
         int_in  = value_fixed[VAL_W-1:FRAC_W];
         frac_in = value_fixed[FRAC_W-1:0];
      end
      if (cmd.mul_scale) begin
         sprod_in = {{DEN_W{1'b0}}, frac_ff} * {{FRAC_W{1'b0}}, PREC_C};
      end
      if (cmd.load_gcd) begin
         // round to nearest step, ties up; never exceeds the precision
         scaled_in = sround[FRAC_W +: DEN_W];
         gx_in     = sround[FRAC_W +: DEN_W];
         gy_in     = PREC_C;
      end
      if (cmd.gcd_step) begin
         gx_in = gy_ff;
         gy_in = div_rem;
      end
      if (cmd.take_num) begin
         num_in = div_quo;
      end
      if (cmd.take_den) begin
         den_in = div_quo;
      end
      if (cmd.mul_den) begin
         mprod_in = MP_W'(int_ff) * MP_W'($signed({1'b0, den_ff}));
      end
      if (cmd.load_out) begin
         onum_in   = {{(VAL_W - MP_W){mprod_ff[MP_W-1]}}, mprod_ff}
                   + {{(VAL_W - DEN_W){1'b0}}, num_ff};
         oden_in   = den_ff;
         owhole_in = (den_ff == DEN_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      int_ff    <= int_in;
      frac_ff   <= frac_in;
      sprod_ff  <= sprod_in;
      scaled_ff <= scaled_in;
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      mprod_ff  <= mprod_in;
      onum_ff   <= onum_in;
      oden_ff   <= oden_in;
      owhole_ff <= owhole_in;
   end

   assign status.gy_zero  = (gy_ff == '0);
   assign status.div_done = div_done;

   assign numerator   = onum_ff;
   assign denominator = oden_ff;
   assign is_whole    = owhole_ff;

   // gcd of anything with the precision is at least 1, and Euclid only divides by nonzero gy
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> div_divisor != '0)
      else $error("divider started with zero divisor");

endmodule

`default_nettype wire

>>> hw/rtl/dtf_ctrl.sv
// Controller state machine: sequences scaling, Euclid steps, the two final
// divisions and result assembly. Uses dtf_pkg.
`default_nettype none

module dtf_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output dtf_pkg::dtf_cmd_type         cmd,
   input  wire dtf_pkg::dtf_status_type status
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b0_0000_0001,
      ST_SCALE  = 9'b0_0000_0010,
      ST_ROUND  = 9'b0_0000_0100,
      ST_CHECK  = 9'b0_0000_1000,
      ST_GCD    = 9'b0_0001_0000,
      ST_NUM    = 9'b0_0010_0000,
      ST_DEN    = 9'b0_0100_0000,
      ST_MULT   = 9'b0_1000_0000,
      ST_FINISH = 9'b1_0000_0000
   } dtf_state_type;

   dtf_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.mul_scale = 1'b1;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.load_gcd = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.div_start = 1'b1;
            if (status.gy_zero) begin
               // gx holds the gcd: reduce the numerator next
               cmd.div_sel = dtf_pkg::DIV_NUM;
               state_in    = ST_NUM;
            end else begin
               cmd.div_sel = dtf_pkg::DIV_GCD;
               state_in    = ST_GCD;
            end
         end
         ST_GCD: begin
            if (status.div_done) begin
               cmd.gcd_step = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_NUM: begin
            cmd.div_sel = dtf_pkg::DIV_NUM;
            if (status.div_done) begin
               cmd.take_num  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = dtf_pkg::DIV_DEN;
               state_in      = ST_DEN;
            end
         end
         ST_DEN: begin
            cmd.div_sel = dtf_pkg::DIV_DEN;
            if (status.div_done) begin
               cmd.take_den = 1'b1;
               state_in     = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mul_den = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // wait until the output register is free or being drained
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_start_states: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (state_ff == ST_CHECK || state_ff == ST_NUM))
      else $error("divider started outside Euclid or numerator step");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (state_ff == ST_IDLE && rsp_valid))
      else $error("result load did not return to idle with valid output");

endmodule

`default_nettype wire
